FILE: rtl/mgps_pkg.sv
// ----------------------------------------------------------------------------
// mgps_pkg
// Shared types and constants of the mirror grid pattern sequencer.
// ----------------------------------------------------------------------------
package mgps_pkg;

  localparam int unsigned DivBits   = 8;
  localparam int unsigned LaneCount = 3;
  localparam int unsigned LaneCol   = 0;
  localparam int unsigned LaneRow   = 1;
  localparam int unsigned LaneHgt   = 2;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_BLOCK  = 3'd1;
  localparam logic [2:0] CFG_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_CYCLES = 3'd4;

  localparam logic [3:0] MODE_XY        = 4'd0;
  localparam logic [3:0] MODE_X         = 4'd1;
  localparam logic [3:0] MODE_Y         = 4'd2;
  localparam logic [3:0] MODE_XDIAG     = 4'd3;
  localparam logic [3:0] MODE_YDIAG     = 4'd4;
  localparam logic [3:0] MODE_XY_OFF    = 4'd5;
  localparam logic [3:0] MODE_X_OFF     = 4'd6;
  localparam logic [3:0] MODE_Y_OFF     = 4'd7;
  localparam logic [3:0] MODE_X_Y       = 4'd8;
  localparam logic [3:0] MODE_XDIAG_OFF = 4'd9;
  localparam logic [3:0] MODE_YDIAG_OFF = 4'd10;
  localparam logic [3:0] MODE_XD_YD     = 4'd11;

  typedef enum logic [2:0] {
    PAT_XY    = 3'd0,
    PAT_X     = 3'd1,
    PAT_Y     = 3'd2,
    PAT_XDIAG = 3'd3,
    PAT_YDIAG = 3'd4
  } pat_e;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  block;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [10:0] cycles;
  } cfg_t;

  typedef struct packed {
    logic oor;
    logic zero;
    logic neg;
    pat_e pat;
  } ctrl_t;

  typedef struct packed {
    ctrl_t                                 ctrl;
    logic [DivBits-1:0]                    div;
    logic [LaneCount-1:0][DivBits-1:0]     num;
  } front_t;

  typedef struct packed {
    ctrl_t                                 ctrl;
    logic [DivBits-1:0]                    div;
    logic [LaneCount-1:0][DivBits-1:0]     num;
    logic [LaneCount-1:0][DivBits-1:0]     rem;
    logic [LaneCount-1:0][1:0]             quo;
  } div_stage_t;

endpackage

FILE: rtl/mgps_front.sv
// ----------------------------------------------------------------------------
// mgps_front
// Input stage: clamps the configuration, checks the range and decodes the
// sequence mode into a pattern, sign and blanking flag.
// ----------------------------------------------------------------------------
module mgps_front #(
  parameter int unsigned MAX_SIDE   = 128,
  parameter int unsigned MAX_CYCLES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mgps_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [11:0]           frame_i,
  input  logic [6:0]            column_i,
  input  logic [6:0]            row_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mgps_pkg::front_t      out_o
);

  localparam int unsigned SideLim  = (MAX_SIDE > 255) ? 255 : MAX_SIDE;
  localparam int unsigned CycLim   = (MAX_CYCLES > 2047) ? 2047 : MAX_CYCLES;
  localparam logic [7:0]  SideSat  = 8'(SideLim);
  localparam logic [10:0] CycSat   = 11'(CycLim);

  logic              valid_q;
  logic              load;
  mgps_pkg::front_t  data_d;
  mgps_pkg::front_t  data_q;

  logic [7:0]  b_eff;
  logic [7:0]  w_sat;
  logic [7:0]  h_sat;
  logic [10:0] c_sat;
  logic [12:0] frames;
  logic        second;
  logic        oor;

  always_comb begin
    b_eff = (cfg_i.block == 8'd0) ? 8'd1 : cfg_i.block;
    w_sat = (32'(cfg_i.width) > MAX_SIDE) ? SideSat : cfg_i.width;
    h_sat = (32'(cfg_i.height) > MAX_SIDE) ? SideSat : cfg_i.height;
    c_sat = (32'(cfg_i.cycles) > MAX_CYCLES) ? CycSat : cfg_i.cycles;

    if (cfg_i.mode <= mgps_pkg::MODE_YDIAG) begin
      frames = 13'd2;
    end else if (cfg_i.mode <= mgps_pkg::MODE_XD_YD) begin
      frames = {c_sat, 2'b00};
    end else begin
      frames = 13'd0;
    end

    oor = ({1'b0, frame_i} >= frames) || ({1'b0, column_i} >= w_sat)
       || ({1'b0, row_i} >= h_sat);
    second = (cfg_i.mode >= mgps_pkg::MODE_XY_OFF) && (frame_i >= {c_sat, 1'b0});

    data_d.ctrl.oor  = oor;
    data_d.ctrl.neg  = frame_i[0];
    data_d.ctrl.zero = second && (cfg_i.mode != mgps_pkg::MODE_X_Y)
                    && (cfg_i.mode != mgps_pkg::MODE_XD_YD);
    case (cfg_i.mode)
      mgps_pkg::MODE_XY, mgps_pkg::MODE_XY_OFF:         data_d.ctrl.pat = mgps_pkg::PAT_XY;
      mgps_pkg::MODE_X, mgps_pkg::MODE_X_OFF:           data_d.ctrl.pat = mgps_pkg::PAT_X;
      mgps_pkg::MODE_Y, mgps_pkg::MODE_Y_OFF:           data_d.ctrl.pat = mgps_pkg::PAT_Y;
      mgps_pkg::MODE_XDIAG, mgps_pkg::MODE_XDIAG_OFF:   data_d.ctrl.pat = mgps_pkg::PAT_XDIAG;
      mgps_pkg::MODE_YDIAG, mgps_pkg::MODE_YDIAG_OFF:   data_d.ctrl.pat = mgps_pkg::PAT_YDIAG;
      mgps_pkg::MODE_X_Y:
        data_d.ctrl.pat = second ? mgps_pkg::PAT_Y : mgps_pkg::PAT_X;
      default:
        data_d.ctrl.pat = second ? mgps_pkg::PAT_YDIAG : mgps_pkg::PAT_XDIAG;
    endcase

    data_d.div                      = b_eff;
    data_d.num[mgps_pkg::LaneCol]   = {1'b0, column_i};
    data_d.num[mgps_pkg::LaneRow]   = {1'b0, row_i};
    data_d.num[mgps_pkg::LaneHgt]   = h_sat;
  end

  assign load       = !valid_q || out_ready_i;
  assign in_ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

FILE: rtl/mgps_div.sv
// ----------------------------------------------------------------------------
// mgps_div
// Pipelined restoring divider: one quotient bit per stage for the column,
// row and height lanes, all by the block size. Keeps the two low quotient
// bits of each lane.
// ----------------------------------------------------------------------------
module mgps_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  mgps_pkg::front_t        in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output mgps_pkg::div_stage_t    out_o
);

  localparam int unsigned NumStages = mgps_pkg::DivBits;

  logic                  valid_q [NumStages];
  mgps_pkg::div_stage_t  stage_q [NumStages];
  logic                  stg_ready [NumStages+1];

  assign stg_ready[NumStages] = out_ready_i;

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    mgps_pkg::div_stage_t  src;
    mgps_pkg::div_stage_t  nxt;
    logic                  src_valid;

    if (k == 0) begin : g_first
      always_comb begin
        src.ctrl  = in_i.ctrl;
        src.div   = in_i.div;
        src.num   = in_i.num;
        src.rem   = '0;
        src.quo   = '0;
        src_valid = in_valid_i;
      end
    end else begin : g_next
      always_comb begin
        src       = stage_q[k-1];
        src_valid = valid_q[k-1];
      end
    end

    always_comb begin
      logic [mgps_pkg::DivBits:0] trial;
      logic                       ge;
      nxt = src;
      for (int j = 0; j < mgps_pkg::LaneCount; j++) begin
        trial = {src.rem[j], src.num[j][NumStages-1-k]};
        ge    = trial >= {1'b0, src.div};
        nxt.rem[j] = ge ? mgps_pkg::DivBits'(trial - {1'b0, src.div})
                        : trial[mgps_pkg::DivBits-1:0];
        nxt.quo[j] = {src.quo[j][0], ge};
      end
    end

    assign stg_ready[k] = !valid_q[k] || stg_ready[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stg_ready[k]) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_ready[k] && src_valid) begin
        stage_q[k] <= nxt;
      end
    end
  end

  assign in_ready_o  = stg_ready[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign out_o       = stage_q[NumStages-1];

endmodule

FILE: rtl/mgps_pattern.sv
// ----------------------------------------------------------------------------
// mgps_pattern
// Output stage: forms the grid value from the cell parities and diagonal
// phases, applies sign and blanking, and holds the result for transfer.
// ----------------------------------------------------------------------------
module mgps_pattern (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  mgps_pkg::div_stage_t    in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [1:0]       pixel_value_o,
  output logic                    out_of_range_o
);

  logic               valid_q;
  logic               load;
  logic signed [1:0]  pix_d;
  logic signed [1:0]  pix_q;
  logic               oor_q;

  logic [1:0]         cx;
  logic [1:0]         cy;
  logic [1:0]         hb;
  logic [1:0]         diag;
  logic signed [1:0]  sx;
  logic signed [1:0]  sy;
  logic signed [1:0]  val;

  always_comb begin
    cx   = in_i.quo[mgps_pkg::LaneCol];
    cy   = in_i.quo[mgps_pkg::LaneRow];
    hb   = in_i.quo[mgps_pkg::LaneHgt];
    sx   = cx[0] ? -2'sd1 : 2'sd1;
    sy   = cy[0] ? -2'sd1 : 2'sd1;
    diag = (in_i.ctrl.pat == mgps_pkg::PAT_XDIAG) ? 2'(cx + cy) : 2'(cx + hb - cy);
    case (in_i.ctrl.pat)
      mgps_pkg::PAT_XY: val = (cx[0] ^ cy[0]) ? -2'sd1 : 2'sd1;
      mgps_pkg::PAT_X:  val = sx;
      mgps_pkg::PAT_Y:  val = sy;
      default: begin
        case (diag)
          2'd0:    val = 2'sd1;
          2'd2:    val = -2'sd1;
          default: val = 2'sd0;
        endcase
      end
    endcase
    if (in_i.ctrl.oor || in_i.ctrl.zero) begin
      pix_d = 2'sd0;
    end else if (in_i.ctrl.neg) begin
      pix_d = -val;
    end else begin
      pix_d = val;
    end
  end

  assign load       = !valid_q || out_ready_i;
  assign in_ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      pix_q <= pix_d;
      oor_q <= in_i.ctrl.oor;
    end
  end

  assign out_valid_o    = valid_q;
  assign pixel_value_o  = pix_q;
  assign out_of_range_o = oor_q;

endmodule

FILE: rtl/mirror_grid_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// mirror_grid_pattern_sequencer
// Pipeline: front stage, eight divider stages and output stage, each one
// registered. Throughput: one item per cycle while the output is not stalled,
// set by the one-bit-per-stage block-size divider; stages fill bubbles on stall.
// Reset: clears all stage valid bits and loads the configuration defaults
// (mode 0, block 1, width 50, height 50, cycles 1).
// ----------------------------------------------------------------------------
module mirror_grid_pattern_sequencer #(
  parameter int unsigned MAX_SIDE   = 128,
  parameter int unsigned MAX_CYCLES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [10:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // frame_index[11:0], column[18:12], row[25:19]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // pixel_value[1:0]
  output logic         m_axis_tuser    // out_of_range[0]
);

  mgps_pkg::cfg_t        cfg_q;
  mgps_pkg::front_t      front;
  mgps_pkg::div_stage_t  quot;
  logic                  front_valid;
  logic                  front_ready;
  logic                  div_valid;
  logic                  div_ready;
  logic signed [1:0]     pixel_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= 4'd0;
      cfg_q.block  <= 8'd1;
      cfg_q.width  <= 8'd50;
      cfg_q.height <= 8'd50;
      cfg_q.cycles <= 11'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mgps_pkg::CFG_MODE:   cfg_q.mode   <= cfg_data_i[3:0];
        mgps_pkg::CFG_BLOCK:  cfg_q.block  <= cfg_data_i[7:0];
        mgps_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data_i[7:0];
        mgps_pkg::CFG_HEIGHT: cfg_q.height <= cfg_data_i[7:0];
        mgps_pkg::CFG_CYCLES: cfg_q.cycles <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mgps_front #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_CYCLES (MAX_CYCLES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .frame_i     (s_axis_tdata[11:0]),
    .column_i    (s_axis_tdata[18:12]),
    .row_i       (s_axis_tdata[25:19]),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_o       (front)
  );

  mgps_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_i        (front),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (quot)
  );

  mgps_pattern u_pattern (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (div_valid),
    .in_ready_o     (div_ready),
    .in_i           (quot),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .pixel_value_o  (pixel_value),
    .out_of_range_o (m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, pixel_value};

endmodule
